>>> rtl/core/clns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
package clns_pkg;

  localparam int BitHoldW = 10;
  localparam int LongWaitW = 16;
  localparam int FuncWaitW = 10;
  localparam int ClearWaitW = 12;
  localparam int CfgDataW = 16;
  localparam int CfgIndexW = 3;
  localparam int HoldW = 17;
  localparam int PinW = 7;
  localparam int InitBytes = 6;
  localparam int WakeNibbles = 4;

  // request command codes
  localparam logic [1:0] CMD_INSTR = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_BIT_HOLD   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_POWER_ON   = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_INIT_STEP  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_FUNC_SET   = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_CLEAR_WAIT = 3'd4;

  // LCD instruction bytes used during init
  localparam logic [7:0] LCD_FUNC_SET8 = 8'h38;
  localparam logic [7:0] LCD_FUNC_SET4 = 8'h28;
  localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
  localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0c;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_ADDR0     = 8'h80;

  typedef enum logic [1:0] {
    KIND_POWER,
    KIND_WAKE,
    KIND_BYTE
  } word_kind_t;

  typedef enum logic [1:0] {
    PH_SETUP,
    PH_STROBE,
    PH_HOLD
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic [15:0] extra_wait_us;
  } req_t;

  typedef struct packed {
    logic [PinW-1:0]  pin_word;
    logic [HoldW-1:0] hold_us;
    logic             last;
  } pin_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    word_kind_t kind;
    phase_t     phase;
    logic       high;
    logic       init;
    logic [1:0] wake_idx;
    logic [2:0] byte_idx;
    logic       last;
  } ctl_t;

  typedef struct packed {
    logic out_ready;
  } sts_t;

endpackage

>>> rtl/core/clns_ctrl.sv
// Sequencing state machine: walks words, nibbles and init steps.
module clns_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  logic [1:0]      cmd_code,
  output logic            cmd_stall,
  input  clns_pkg::sts_t  sts,
  output clns_pkg::ctl_t  ctl
);
  import clns_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POWER,
    S_WAKE,
    S_BYTE
  } state_t;

  state_t     state;
  phase_t     phase;
  logic       high;
  logic       init;
  logic [1:0] wake_idx;
  logic [2:0] byte_idx;
  logic       accept;
  logic       advance;
  logic       last_word;
  phase_t     phase_next;

  localparam logic [2:0] LastInitByte = 3'(InitBytes - 1);
  localparam logic [1:0] LastWake = 2'(WakeNibbles - 1);

  always_comb begin
    unique case (phase)
      PH_SETUP:  phase_next = PH_STROBE;
      PH_STROBE: phase_next = PH_HOLD;
      default:   phase_next = PH_SETUP;
    endcase
  end

  assign last_word = (state == S_BYTE) && !high && (phase == PH_HOLD) &&
                     (!init || (byte_idx == LastInitByte));
  // next request may enter in the cycle the final word leaves
  assign cmd_stall = !((state == S_IDLE) || (last_word && sts.out_ready));
  assign accept = cmd_valid && !cmd_stall;
  assign advance = (state != S_IDLE) && sts.out_ready;

  always_comb begin
    ctl.load = accept;
    ctl.emit = (state != S_IDLE);
    unique case (state)
      S_POWER: ctl.kind = KIND_POWER;
      S_WAKE:  ctl.kind = KIND_WAKE;
      default: ctl.kind = KIND_BYTE;
    endcase
    ctl.phase = phase;
    ctl.high = high;
    ctl.init = init;
    ctl.wake_idx = wake_idx;
    ctl.byte_idx = byte_idx;
    ctl.last = last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_SETUP;
      high <= 1'b1;
      init <= 1'b0;
      wake_idx <= '0;
      byte_idx <= '0;
    end else if (accept) begin
      phase <= PH_SETUP;
      high <= 1'b1;
      wake_idx <= '0;
      byte_idx <= '0;
      unique case (cmd_code)
        CMD_INSTR, CMD_DATA: begin
          state <= S_BYTE;
          init <= 1'b0;
        end
        CMD_INIT: begin
          state <= S_POWER;
          init <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end else if (advance) begin
      unique case (state)
        S_POWER: begin
          state <= S_WAKE;
          phase <= PH_SETUP;
          wake_idx <= '0;
        end
        S_WAKE: begin
          phase <= phase_next;
          if (phase == PH_HOLD) begin
            if (wake_idx == LastWake) begin
              state <= S_BYTE;
              high <= 1'b1;
              byte_idx <= '0;
            end else begin
              wake_idx <= wake_idx + 2'd1;
            end
          end
        end
        S_BYTE: begin
          phase <= phase_next;
          if (phase == PH_HOLD) begin
            if (high) begin
              high <= 1'b0;
            end else if (init && (byte_idx != LastInitByte)) begin
              byte_idx <= byte_idx + 3'd1;
              high <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/clns_dp.sv
// Datapath: config registers, request latch, pin word build, output register.
module clns_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [clns_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [clns_pkg::CfgDataW-1:0]  cfg_data,
  input  clns_pkg::req_t                 req,
  input  clns_pkg::ctl_t                 ctl,
  output clns_pkg::sts_t                 sts,
  output logic                           pin_valid,
  input  logic                           pin_stall,
  output clns_pkg::pin_t                 pin
);
  import clns_pkg::*;

  logic [BitHoldW-1:0]   bit_hold;
  logic [LongWaitW-1:0]  power_on_wait;
  logic [LongWaitW-1:0]  init_step_wait;
  logic [FuncWaitW-1:0]  func_set_wait;
  logic [ClearWaitW-1:0] clear_wait;
  req_t                  req_r;
  logic [7:0]            cur_byte;
  logic [3:0]            nib;
  logic                  rs;
  logic [15:0]           extra;
  logic [15:0]           init_extra;
  pin_t                  word_next;
  logic                  out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_hold <= 10'd41;
      power_on_wait <= 16'd15000;
      init_step_wait <= 16'd50000;
      func_set_wait <= 10'd50;
      clear_wait <= 12'd1640;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_HOLD:   bit_hold <= cfg_data[BitHoldW-1:0];
        REG_POWER_ON:   power_on_wait <= cfg_data;
        REG_INIT_STEP:  init_step_wait <= cfg_data;
        REG_FUNC_SET:   func_set_wait <= cfg_data[FuncWaitW-1:0];
        REG_CLEAR_WAIT: clear_wait <= cfg_data[ClearWaitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= req;
    end
  end

  // init byte sequence and the extra wait each one ends with
  always_comb begin
    unique case (ctl.byte_idx)
      3'd0: begin
        cur_byte = LCD_FUNC_SET4;
        init_extra = 16'(func_set_wait);
      end
      3'd1: begin
        cur_byte = LCD_DISP_OFF;
        init_extra = '0;
      end
      3'd2: begin
        cur_byte = LCD_CLR_DISP;
        init_extra = 16'(clear_wait);
      end
      3'd3: begin
        cur_byte = LCD_DISP_ON;
        init_extra = '0;
      end
      3'd4: begin
        cur_byte = LCD_ENTRY;
        init_extra = '0;
      end
      default: begin
        cur_byte = LCD_ADDR0;
        init_extra = '0;
      end
    endcase
    if (!ctl.init) begin
      cur_byte = req_r.byte_value;
    end
  end

  always_comb begin
    rs = !ctl.init && (req_r.command == CMD_DATA);
    extra = '0;
    if (ctl.kind == KIND_WAKE) begin
      nib = (ctl.wake_idx == 2'(WakeNibbles - 1)) ? LCD_FUNC_SET4[7:4] : LCD_FUNC_SET8[7:4];
      if (ctl.phase == PH_HOLD) extra = init_step_wait;
    end else begin
      nib = ctl.high ? cur_byte[7:4] : cur_byte[3:0];
      if (ctl.phase == PH_HOLD && !ctl.high) begin
        extra = ctl.init ? init_extra : req_r.extra_wait_us;
      end
    end

    if (ctl.kind == KIND_POWER) begin
      word_next.pin_word = '0;
      word_next.hold_us = HoldW'(power_on_wait);
    end else begin
      word_next.pin_word = {ctl.phase == PH_STROBE, rs, 1'b0, nib};
      word_next.hold_us = HoldW'(bit_hold) + HoldW'(extra);
    end
    word_next.last = ctl.last;
  end

  assign out_ready = !pin_valid || !pin_stall;
  assign sts.out_ready = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_valid <= 1'b0;
    end else if (out_ready) begin
      pin_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && ctl.emit) begin
      pin <= word_next;
    end
  end

endmodule

>>> rtl/core/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit nibble sequencer.
//
// Request channel (cmd_valid/cmd_stall/cmd): one command per request:
// instruction byte, data byte, or the init sequence. Result channel
// (pin_valid/pin_stall/pin): one 7-bit pin word per item with its hold time
// in microseconds; last marks the final word of a request.
// Config port: cfg_we writes cfg_data into register cfg_index, no wait.
// A taken request is first registered in the sequencer state; the first pin
// word then enters the output register. A byte request yields 6 words, one
// per cycle while the result side does not stall; init yields 49 words. The
// request side is stalled while a command is being walked; the next request
// is taken in the cycle its predecessor's final word enters the output
// register. One word is produced per cycle by the sequencer state machine
// while the result side does not stall.
// A stall on the result side freezes the output register and the sequencer.
// Reset clears the sequencer and output valid and loads the config defaults.
module char_lcd_nibble_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [clns_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [clns_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  clns_pkg::req_t                 cmd,
  output logic                           pin_valid,
  input  logic                           pin_stall,
  output clns_pkg::pin_t                 pin
);
  import clns_pkg::*;

  ctl_t ctl;
  sts_t sts;

  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_code (cmd.command),
    .cmd_stall(cmd_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  clns_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (cmd),
    .ctl      (ctl),
    .sts      (sts),
    .pin_valid(pin_valid),
    .pin_stall(pin_stall),
    .pin      (pin)
  );

  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    (ctl.last && sts.out_ready) |=> (pin_valid && pin.last))
    else $error("final word did not reach output register");

  a_init_starts_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.command == CMD_INIT) |=>
    (ctl.emit && ctl.kind == KIND_POWER))
    else $error("init request did not start with power-on word");

  a_last_enable_low: assert property (@(posedge clk) disable iff (rst)
    (pin_valid && pin.last) |-> !pin.pin_word[6])
    else $error("final word has enable high");

endmodule
